// ===== src/wsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants
// Widths, fixed-point constants, register indexes, controller states and the
// command bundle between the controller and the datapath.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Fixed-point format: unsigned Q1.FracBits, OneQ means 1.0
  localparam int unsigned FracBits   = 15;
  localparam int unsigned ScoreW     = 16;
  localparam int unsigned LevelW     = 16;
  localparam int unsigned WeightW    = 16;
  localparam int unsigned RecipW     = 32;
  localparam int unsigned RecipShift = 16;
  localparam int unsigned CountW     = 16;
  localparam int unsigned CountOutW  = 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;

  // Shared multiplier: WeightW x RecipW unsigned
  localparam int unsigned ProdW      = WeightW + RecipW;
  // Weighted sum of two WeightW x ScoreW products, with no bit of growth
  localparam int unsigned AccW       = WeightW + ScoreW;

  localparam logic [ScoreW-1:0] OneQ     = ScoreW'(1 << FracBits);
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACCEL_RECIP  = 3'd0,
    CFG_GLASS_WEIGHT = 3'd1,
    CFG_ACCEL_WEIGHT = 3'd2,
    CFG_ACT_THR      = 3'd3,
    CFG_REL_THR      = 3'd4,
    CFG_DEB_LEN      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [RecipW-1:0]  accel_recip;
    logic [WeightW-1:0] glass_weight;
    logic [WeightW-1:0] accel_weight;
    logic [ScoreW-1:0]  act_thr;
    logic [ScoreW-1:0]  rel_thr;
    logic [15:0]        deb_len;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GLASS,
    ST_ACCEL,
    ST_FIN
  } state_e;

  // Controller to datapath commands, at most one active per cycle
  typedef struct packed {
    logic load;       // capture item, normalize accel on the multiplier
    logic mul_glass;  // glass weight x clamped glass level into accumulator
    logic mul_accel;  // accel weight x normalized accel added to accumulator
    logic commit;     // clamp score, update debounce state and result
  } cmd_t;

endpackage

// ===== src/wsd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_cfg_regs: configuration register bank
// Six registers written by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module wsd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [wsd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [wsd_pkg::CfgDataW-1:0]   cfg_data_i,
  output wsd_pkg::cfg_t                  cfg_o
);

  wsd_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (wsd_pkg::cfg_idx_e'(cfg_index_i))
        wsd_pkg::CFG_ACCEL_RECIP:  cfg_d.accel_recip  = cfg_data_i[wsd_pkg::RecipW-1:0];
        wsd_pkg::CFG_GLASS_WEIGHT: cfg_d.glass_weight = cfg_data_i[wsd_pkg::WeightW-1:0];
        wsd_pkg::CFG_ACCEL_WEIGHT: cfg_d.accel_weight = cfg_data_i[wsd_pkg::WeightW-1:0];
        wsd_pkg::CFG_ACT_THR:      cfg_d.act_thr      = cfg_data_i[wsd_pkg::ScoreW-1:0];
        wsd_pkg::CFG_REL_THR:      cfg_d.rel_thr      = cfg_data_i[wsd_pkg::ScoreW-1:0];
        wsd_pkg::CFG_DEB_LEN:      cfg_d.deb_len      = cfg_data_i[15:0];
        default: ;  // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_recip  <= '0;
      cfg_q.glass_weight <= '0;
      cfg_q.accel_weight <= '0;
      cfg_q.act_thr      <= wsd_pkg::OneQ;
      cfg_q.rel_thr      <= '0;
      cfg_q.deb_len      <= 16'd200;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/wsd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_ctrl: sequencing controller
// Steps one item through the shared multiplier and owns the result valid flag.
// ----------------------------------------------------------------------------
module wsd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output wsd_pkg::cmd_t cmd_o
);

  wsd_pkg::state_e state_d, state_q;
  logic            out_valid_d, out_valid_q;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      wsd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = wsd_pkg::ST_GLASS;
        end
      end
      wsd_pkg::ST_GLASS: begin
        cmd_o.mul_glass = 1'b1;
        state_d         = wsd_pkg::ST_ACCEL;
      end
      wsd_pkg::ST_ACCEL: begin
        cmd_o.mul_accel = 1'b1;
        state_d         = wsd_pkg::ST_FIN;
      end
      wsd_pkg::ST_FIN: begin
        // hold until the result slot is free
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = wsd_pkg::ST_IDLE;
        end
      end
      default: state_d = wsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wsd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/wsd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_datapath: fusion arithmetic and debounce state
// One shared multiplier, accumulator, clamps and the hysteresis counter.
// ----------------------------------------------------------------------------
module wsd_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wsd_pkg::cmd_t                     cmd_i,
  input  wsd_pkg::cfg_t                     cfg_i,
  input  logic signed [wsd_pkg::LevelW-1:0] accel_level_i,
  input  logic signed [wsd_pkg::LevelW-1:0] glass_level_i,
  output logic [wsd_pkg::ScoreW-1:0]        score_o,
  output logic                              detected_o,
  output logic [wsd_pkg::CountOutW-1:0]     count_o
);

  // operand selection for the shared multiplier
  logic [wsd_pkg::WeightW-1:0] mul_a;
  logic [wsd_pkg::RecipW-1:0]  mul_b;
  logic [wsd_pkg::ProdW-1:0]   prod;
  logic [wsd_pkg::RecipW-1:0]  norm_raw;

  logic [wsd_pkg::ScoreW-1:0]  norm_d, norm_q;
  logic [wsd_pkg::LevelW-2:0]  glass_d, glass_q;
  logic [wsd_pkg::AccW-1:0]    acc_d, acc_q;

  logic [wsd_pkg::AccW-wsd_pkg::FracBits-1:0] score_raw;
  logic [wsd_pkg::ScoreW-1:0]  score_cl;
  logic [wsd_pkg::CountW-1:0]  cnt_inc;

  logic                        active_d, active_q;
  logic [wsd_pkg::CountW-1:0]  cnt_d, cnt_q;
  logic [wsd_pkg::ScoreW-1:0]  last_score_d, last_score_q;

  always_comb begin
    priority if (cmd_i.load) begin
      mul_a = accel_level_i[wsd_pkg::LevelW-1] ? '0 : wsd_pkg::WeightW'(accel_level_i);
      mul_b = cfg_i.accel_recip;
    end else if (cmd_i.mul_glass) begin
      mul_a = cfg_i.glass_weight;
      mul_b = wsd_pkg::RecipW'(glass_q);
    end else begin
      mul_a = cfg_i.accel_weight;
      mul_b = wsd_pkg::RecipW'(norm_q);
    end
  end

  assign prod     = wsd_pkg::ProdW'(mul_a) * wsd_pkg::ProdW'(mul_b);
  assign norm_raw = prod[wsd_pkg::ProdW-1:wsd_pkg::RecipShift];

  always_comb begin
    norm_d  = norm_q;
    glass_d = glass_q;
    acc_d   = acc_q;
    if (cmd_i.load) begin
      norm_d  = (norm_raw > wsd_pkg::RecipW'(wsd_pkg::OneQ)) ? wsd_pkg::OneQ
                                                             : norm_raw[wsd_pkg::ScoreW-1:0];
      // negative glass clamps to zero; positive levels stay below 1.0
      glass_d = glass_level_i[wsd_pkg::LevelW-1] ? '0 : glass_level_i[wsd_pkg::LevelW-2:0];
    end
    if (cmd_i.mul_glass) begin
      acc_d = prod[wsd_pkg::AccW-1:0];
    end
    if (cmd_i.mul_accel) begin
      acc_d = acc_q + prod[wsd_pkg::AccW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    norm_q  <= norm_d;
    glass_q <= glass_d;
    acc_q   <= acc_d;
  end

  // score clamp and debounce / hysteresis update
  assign score_raw = acc_q[wsd_pkg::AccW-1:wsd_pkg::FracBits];
  assign score_cl  = (score_raw > (wsd_pkg::AccW-wsd_pkg::FracBits)'(wsd_pkg::OneQ))
                   ? wsd_pkg::OneQ : score_raw[wsd_pkg::ScoreW-1:0];
  assign cnt_inc   = (cnt_q != wsd_pkg::CountMax) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    active_d     = active_q;
    cnt_d        = cnt_q;
    last_score_d = last_score_q;
    if (cmd_i.commit) begin
      last_score_d = score_cl;
      if (!active_q) begin
        if (score_cl >= cfg_i.act_thr) begin
          cnt_d = cnt_inc;
          if (cnt_inc >= cfg_i.deb_len) begin
            active_d = 1'b1;
            cnt_d    = wsd_pkg::CountW'(cfg_i.deb_len);
          end
        end else begin
          cnt_d = '0;
        end
      end else if (score_cl < cfg_i.rel_thr) begin
        active_d = 1'b0;
        cnt_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      cnt_q        <= '0;
      last_score_q <= '0;
    end else begin
      active_q     <= active_d;
      cnt_q        <= cnt_d;
      last_score_q <= last_score_d;
    end
  end

  // state changes only at commit, so it doubles as the result register
  assign score_o    = last_score_q;
  assign detected_o = active_q;
  assign count_o    = wsd_pkg::CountOutW'(cnt_q);

endmodule

// ===== src/weighted_score_debounce_detector_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_score_debounce_detector_core: two-sensor fusion with debounce
// Fuses an acceleration peak and a glass-break level into a Q1.15 score and
// runs a debounced detector with hysteresis on it; one result word per item.
// ----------------------------------------------------------------------------
// Each input word passes IDLE, GLASS, ACCEL and FIN from acceptance to the
// commit of its result: one 16x32 multiplier is shared by the three products
// (acceleration times reciprocal, glass weight times glass level, acceleration
// weight times normalized acceleration), one product per cycle, followed by a
// commit step that clamps the score and updates the debounce counter. A new
// input word can be taken in the cycle after the previous result commits, so
// the block works on one word at a time. The result sits in an output
// register; the next input word is accepted while it waits, and the commit of
// that next word waits only if the previous result has not yet been taken.
// Configuration writes are accepted in any cycle (cfg_ready_o is tied high)
// and must be issued only while no item is in flight. Levels are signed with
// negatives clamped to 0; weights, thresholds: unsigned Q1.15, 32768 is 1.0.
module weighted_score_debounce_detector_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] accel_level, [31:16] glass_level

  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] fused_score, [31:16] qualify_count
  output logic        m_axis_tuser,   // [0] detected

  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [wsd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wsd_pkg::CfgDataW-1:0] cfg_data_i
);

  wsd_pkg::cfg_t cfg;
  wsd_pkg::cmd_t cmd;

  logic [wsd_pkg::ScoreW-1:0]    fused_score;
  logic [wsd_pkg::CountOutW-1:0] qualify_count;
  logic                          detected;

  // register bank; always ready
  assign cfg_ready_o = 1'b1;

  wsd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // sequence load, two weighted products and commit
  wsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  // unpack input fields straight into the datapath; they are used only in
  // the acceptance cycle
  wsd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg),
    .accel_level_i (s_axis_tdata[15:0]),
    .glass_level_i (s_axis_tdata[31:16]),
    .score_o       (fused_score),
    .detected_o    (detected),
    .count_o       (qualify_count)
  );

  assign m_axis_tdata = {qualify_count, fused_score};
  assign m_axis_tuser = detected;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // the block works on one item at a time: drop ready after an acceptance
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready
  ) else $error("input ready right after an accepted word");

  // score clamp: never above 1.0
  a_score_clamped: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:0] <= wsd_pkg::OneQ)
  ) else $error("fused score above 1.0");

  // detection state moves only with a committed result
  a_detect_with_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !$stable(m_axis_tuser) |-> m_axis_tvalid
  ) else $error("detected changed without a result word");

  // a result word must not rise before the commit of the accepted word
  a_result_latency: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> ##2 !$rose(m_axis_tvalid)
  ) else $error("result committed too early");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for weighted_score_debounce_detector_core
// Drives acceleration/glass input words and configuration writes, predicts
// score, detect flag and debounce count per word, and checks every result.
// ----------------------------------------------------------------------------
module testbench;

  // Indexes past the end of the register list; the block must ignore them
  localparam logic [wsd_pkg::CfgIdxW-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [wsd_pkg::CfgIdxW-1:0] CFG_UNUSED_HI = 3'd7;

  // Reciprocal for a full scale of 16384 sensor units: 2^31 / 16384
  localparam logic [31:0] RECIP_FS16K = 32'h0002_0000;

  typedef struct packed {
    logic [wsd_pkg::ScoreW-1:0]    fused_score;
    logic                          detected;
    logic [wsd_pkg::CountOutW-1:0] qualify_count;
  } result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the register file and the debounce state, predicts
  // one result per accepted input word and compares against result words.
  // --------------------------------------------------------------------------
  class fusion_scoreboard;
    wsd_pkg::cfg_t              cfg;
    logic                       active;
    logic [wsd_pkg::CountW-1:0] count;
    result_t                    pending_results[$];
    int unsigned                errors;

    function new();
      cfg.accel_recip  = '0;
      cfg.glass_weight = '0;
      cfg.accel_weight = '0;
      cfg.act_thr      = wsd_pkg::OneQ;
      cfg.rel_thr      = '0;
      cfg.deb_len      = 16'd200;
      active           = 1'b0;
      count            = '0;
      errors           = 0;
    endfunction

    // Mirror a register write; narrow registers keep their low bits only
    function void write_reg(logic [wsd_pkg::CfgIdxW-1:0] idx,
                            logic [wsd_pkg::CfgDataW-1:0] data);
      case (idx)
        wsd_pkg::CFG_ACCEL_RECIP:  cfg.accel_recip  = data;
        wsd_pkg::CFG_GLASS_WEIGHT: cfg.glass_weight = data[wsd_pkg::WeightW-1:0];
        wsd_pkg::CFG_ACCEL_WEIGHT: cfg.accel_weight = data[wsd_pkg::WeightW-1:0];
        wsd_pkg::CFG_ACT_THR:      cfg.act_thr      = data[wsd_pkg::ScoreW-1:0];
        wsd_pkg::CFG_REL_THR:      cfg.rel_thr      = data[wsd_pkg::ScoreW-1:0];
        wsd_pkg::CFG_DEB_LEN:      cfg.deb_len      = data[15:0];
        default: ;
      endcase
    endfunction

    function result_t predict_result(logic [wsd_pkg::LevelW-1:0] accel,
                                     logic [wsd_pkg::LevelW-1:0] glass);
      longint unsigned accel_pos;
      longint unsigned glass_pos;
      longint unsigned norm;
      longint unsigned sum;
      longint unsigned score;
      result_t         res;
      // Negative levels clamp to zero; positive glass never exceeds 1.0
      accel_pos = accel[wsd_pkg::LevelW-1] ? 64'd0 : 64'(accel);
      glass_pos = glass[wsd_pkg::LevelW-1] ? 64'd0 : 64'(glass);
      norm = (accel_pos * cfg.accel_recip) >> wsd_pkg::RecipShift;
      if (norm > wsd_pkg::OneQ) norm = 64'(wsd_pkg::OneQ);
      sum = cfg.glass_weight * glass_pos + cfg.accel_weight * norm;
      score = sum >> wsd_pkg::FracBits;
      if (score > wsd_pkg::OneQ) score = 64'(wsd_pkg::OneQ);
      if (!active) begin
        if (score >= cfg.act_thr) begin
          if (count != wsd_pkg::CountMax) count++;
          if (count >= cfg.deb_len) begin
            active = 1'b1;
            count  = cfg.deb_len;
          end
        end else begin
          count = '0;
        end
      end else if (score < cfg.rel_thr) begin
        active = 1'b0;
        count  = '0;
      end
      res.fused_score   = score[wsd_pkg::ScoreW-1:0];
      res.detected      = active;
      res.qualify_count = count[wsd_pkg::CountOutW-1:0];
      return res;
    endfunction

    function void note_word(logic [wsd_pkg::LevelW-1:0] accel,
                            logic [wsd_pkg::LevelW-1:0] glass);
      pending_results.push_back(predict_result(accel, glass));
    endfunction

    function void check_word(logic [wsd_pkg::ScoreW-1:0] score, logic det,
                             logic [wsd_pkg::CountOutW-1:0] count_out);
      result_t exp_res;
      if (pending_results.size() == 0) begin
        errors++;
        $error("result word with no prediction waiting: score %0d", score);
        return;
      end
      exp_res = pending_results.pop_front();
      if (score !== exp_res.fused_score) begin
        errors++;
        $error("fused_score: expected %0d, actual %0d", exp_res.fused_score, score);
      end
      if (det !== exp_res.detected) begin
        errors++;
        $error("detected: expected %0d, actual %0d", exp_res.detected, det);
      end
      if (count_out !== exp_res.qualify_count) begin
        errors++;
        $error("qualify_count: expected %0d, actual %0d",
               exp_res.qualify_count, count_out);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [31:0]                  s_axis_tdata;   // [15:0] accel_level, [31:16] glass_level
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [31:0]                  m_axis_tdata;   // [15:0] fused_score, [31:16] qualify_count
  logic                         m_axis_tuser;   // [0] detected
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [wsd_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [wsd_pkg::CfgDataW-1:0] cfg_data_i;

  weighted_score_debounce_detector_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  fusion_scoreboard sb = new();

  // Upper bounds of the per-word idle draws; changed between phases
  int unsigned src_idle_max = 14;
  int unsigned snk_idle_max = 14;

  // Clock: 20 ns period
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Check every result word at the edge that accepts it. Values read here are
  // the ones from before the edge, so the handshake matches what the block saw.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_word(m_axis_tdata[15:0], m_axis_tuser, m_axis_tdata[31:16]);
    end
  end

  // Result sink: draw a stall per word, then hold ready until a word is taken.
  // Ready gets exactly one assignment per edge, so it never glitches low.
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, snk_idle_max);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks; all of them start and end on a rising edge
  // --------------------------------------------------------------------------

  // Present one input word after a random gap and hold it until accepted
  task automatic send_word(input logic [wsd_pkg::LevelW-1:0] accel,
                           input logic [wsd_pkg::LevelW-1:0] glass);
    int unsigned gap;
    gap = $urandom_range(0, src_idle_max);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {glass, accel};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(accel, glass);
  endtask

  // Drop valid and hold off until every predicted result has been taken
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Issue one register write; valid stays high for back-to-back writes
  task automatic write_reg(input logic [wsd_pkg::CfgIdxW-1:0] idx,
                           input logic [wsd_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  // Write the whole register file plus one write to an unused index
  task automatic configure(input logic [31:0] recip, gw, aw, act, rel, len);
    write_reg(wsd_pkg::CFG_ACCEL_RECIP, recip);
    write_reg(wsd_pkg::CFG_GLASS_WEIGHT, gw);
    write_reg(wsd_pkg::CFG_ACCEL_WEIGHT, aw);
    write_reg(wsd_pkg::CFG_ACT_THR, act);
    write_reg(wsd_pkg::CFG_REL_THR, rel);
    write_reg(wsd_pkg::CFG_DEB_LEN, len);
    write_reg($urandom_range(0, 1) ? CFG_UNUSED_HI : CFG_UNUSED_LO, $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  // Draw a register set: mostly settings where runs of strong inputs reach
  // activation, with the extremes of each register mixed in
  task automatic random_config();
    logic [31:0] recip, gw, aw, act, rel, len;
    case ($urandom_range(0, 5))
      0:       recip = '0;
      1:       recip = '1;
      2:       recip = $urandom;
      default: recip = 32'h8000_0000 / $urandom_range(1, 32767);
    endcase
    gw  = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(8192, 32768);
    aw  = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32768);
    act = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32768) : $urandom_range(2000, 16000);
    rel = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 32768) : $urandom_range(0, act);
    case ($urandom_range(0, 7))
      0:       len = '0;
      1:       len = 32'h0000_FFFF;
      default: len = $urandom_range(1, 8);
    endcase
    // Junk in the upper data bits must be masked off by the narrow registers
    if ($urandom_range(0, 1)) len = len | ($urandom & 32'hFFFF_0000);
    if ($urandom_range(0, 1)) act = act | ($urandom & 32'hFFFF_0000);
    configure(recip, gw, aw, act, rel, len);
  endtask

  // Random words, mostly in runs of strong or weak readings so the debounce
  // counter climbs, activates and releases; the rest is unstructured noise
  task automatic run_random(input int unsigned n_items);
    int unsigned                sent;
    int unsigned                mode;
    int unsigned                run_len;
    logic                       hot;
    logic [wsd_pkg::LevelW-1:0] accel;
    logic [wsd_pkg::LevelW-1:0] glass;
    sent = 0;
    while (sent < n_items) begin
      mode    = $urandom_range(0, 7);
      run_len = (mode == 0) ? 1 : $urandom_range(1, 12);
      hot     = 1'($urandom_range(0, 1));
      repeat (run_len) begin
        if (mode == 0) begin
          accel = 16'($urandom);
          glass = 16'($urandom);
        end else if (hot) begin
          accel = 16'($urandom_range(4000, 32767));
          glass = 16'($urandom_range(12000, 32767));
        end else begin
          accel = ($urandom_range(0, 3) == 0) ? (16'($urandom_range(0, 32767)) | 16'h8000)
                                              : 16'($urandom_range(0, 2000));
          glass = ($urandom_range(0, 3) == 0) ? (16'($urandom_range(0, 32767)) | 16'h8000)
                                              : 16'($urandom_range(0, 4000));
        end
        send_word(accel, glass);
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: zero weights give a zero score that never qualifies
    send_word(16'h7FFF, 16'h7FFF);
    send_word(16'h8000, 16'h8000);
    drain();

    // Half weights, debounce of three: count up, activate, hold inside the
    // hysteresis band, release, then count again and break the run
    configure(RECIP_FS16K, 32'd16384, 32'd16384, 32'd16384, 32'd8192, 32'd3);
    send_word(16'h7FFF, 16'h7FFF);
    send_word(16'h7FFF, 16'h8000);
    send_word(16'd16384, 16'd16384);
    send_word(16'd0, 16'd20000);
    send_word(16'hFFFF, 16'd0);
    send_word(16'h8000, 16'h8000);
    send_word(16'h7FFF, 16'h7FFF);
    send_word(16'd0, 16'd0);
    drain();

    // Largest reciprocal, out-of-range glass weight, thresholds at 1.0 and
    // zero debounce length: the first qualifying word activates with count 0
    configure(32'hFFFF_FFFF, 32'hABCD_FFFF, 32'd32768, 32'd32768, 32'd32768, 32'd0);
    send_word(16'd1, 16'd0);
    send_word(16'd0, 16'd1);
    send_word(16'd0, 16'h7FFF);
    send_word(16'd0, 16'hFFFB);
    drain();

    // Tiny reciprocal and zero threshold: every word qualifies, but the longest
    // debounce length keeps detection off while the count climbs
    configure(32'd1, 32'd0, 32'd32768, 32'd0, 32'd0, 32'd65535);
    send_word(16'h7FFF, 16'd0);
    send_word(16'h4000, 16'h7FFF);
    send_word(16'h8001, 16'h0001);
    drain();

    // Shorten the debounce length in the middle of a run: the next qualifying
    // word activates and loads the new length into the count
    configure(RECIP_FS16K, 32'd32768, 32'd0, 32'd100, 32'd50, 32'd10);
    repeat (4) send_word(16'd0, 16'd30000);
    drain();
    configure(RECIP_FS16K, 32'd32768, 32'd0, 32'd100, 32'd50, 32'd2);
    send_word(16'd0, 16'd30000);
    send_word(16'd0, 16'd60);
    send_word(16'd0, 16'd10);
    drain();

    // Random phases; rotate the idle bounds so both sides run back to back,
    // both stall, and each stalls alone. Each drain lets the pipe run dry.
    for (int p = 0; p < 7; p++) begin
      src_idle_max = (p % 4 == 1 || p % 4 == 3) ? 0 : 14;
      snk_idle_max = (p % 4 == 1 || p % 4 == 2) ? 0 : 14;
      random_config();
      run_random(150);
      drain();
    end

    // Let any stray result word surface before the verdict
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
